// ===== design/cfm_pkg.sv =====
`default_nettype none

package cfm_pkg;

    // Longest line held, terminator included.
    localparam int MAX_LINE = 64;
    localparam int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_PLUS = 8'h2b;

    localparam int         MATCH_LEN = 11;
    localparam logic [3:0] MATCH_END = 4'(MATCH_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic rd_start;  // read first stored byte
        logic rd_next;   // output word taken, read following byte
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic deliver;   // current input word closes a line worth sending
        logic rd_last;   // byte on the output is the final one
    } sts_t;

    // "+HTTPACTION", one character per position
    function automatic logic [7:0] match_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2b; // +
            4'd1:    c = 8'h48; // H
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h54; // T
            4'd4:    c = 8'h50; // P
            4'd5:    c = 8'h41; // A
            4'd6:    c = 8'h43; // C
            4'd7:    c = 8'h54; // T
            4'd8:    c = 8'h49; // I
            4'd9:    c = 8'h4f; // O
            4'd10:   c = 8'h4e; // N
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/cfm_ram.sv =====
`default_nettype none

module cfm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/cfm_datapath.sv =====
`default_nettype none

module cfm_datapath
    import cfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    input  wire logic [7:0] rx_byte,
    output logic      [7:0] line_byte,
    output logic            is_last,
    output logic            http_action
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              prev_cr_reg, prev_cr_next;
    logic [3:0]        prog_reg, prog_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] len_m1_reg, len_m1_next;
    logic              flag_reg, flag_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;

    logic [CNT_W-1:0]  cnt_inc;
    logic [3:0]        p_adv;
    logic              found_adv;
    logic              ends;
    logic              clear;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    always_comb
    begin
        cnt_inc = count_reg + CNT_W'(1);

        // '+' only heads the text, so a mismatch restarts at 0 or 1
        if (rx_byte == match_char(prog_reg))
        begin
            p_adv = prog_reg + 4'd1;
        end
        else
        begin
            p_adv = (rx_byte == CH_PLUS) ? 4'd1 : 4'd0;
        end
        found_adv = found_reg || (p_adv == MATCH_END);

        ends  = prev_cr_reg && (rx_byte == CH_LF);
        clear = ends || (cnt_inc >= CNT_W'(MAX_LINE));
        sts.deliver = ends && (cnt_inc > CNT_W'(2));

        count_next   = count_reg;
        prev_cr_next = prev_cr_reg;
        prog_next    = prog_reg;
        found_next   = found_reg;
        len_m1_next  = len_m1_reg;
        flag_next    = flag_reg;

        if (cmd.accept)
        begin
            if (clear)
            begin
                count_next   = '0;
                prev_cr_next = 1'b0;
                prog_next    = 4'd0;
                found_next   = 1'b0;
            end
            else
            begin
                count_next   = cnt_inc;
                prev_cr_next = (rx_byte == CH_CR);
                prog_next    = (p_adv == MATCH_END) ? 4'd0 : p_adv;
                found_next   = found_adv;
            end
            if (sts.deliver)
            begin
                len_m1_next = count_reg[ADDR_W-1:0];
                flag_next   = found_adv;
            end
        end

        rd_idx_next = rd_idx_reg;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
            rd_en       = 1'b1;
            rd_addr     = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
            rd_en       = 1'b1;
            rd_addr     = rd_idx_next;
        end

        sts.rd_last = (rd_idx_reg == len_m1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            prev_cr_reg <= 1'b0;
            prog_reg    <= 4'd0;
            found_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            prev_cr_reg <= prev_cr_next;
            prog_reg    <= prog_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_m1_reg <= len_m1_next;
        flag_reg   <= flag_next;
        rd_idx_reg <= rd_idx_next;
    end

    cfm_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_LINE),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (line_byte)
    );

    assign is_last     = sts.rd_last;
    assign http_action = flag_reg;

endmodule

`default_nettype wire

// ===== design/cfm_ctrl.sv =====
`default_nettype none

module cfm_ctrl
    import cfm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.rd_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && sts.deliver)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_start = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/crlf_line_framer_with_match.sv =====
`default_nettype none

// Channel   Dir  Word         Sideband
// s_axis    in   tdata[7:0]   -        received byte
// m_axis    out  tdata[7:0]   tlast    line byte, tlast on the final LF
//                             tuser[0] line holds "+HTTPACTION"
//
// Idle: one input word per cycle; bytes go into the line RAM as they arrive.
// A CRLF closing a line of n > 2 bytes leads to a fetch state, then n words
// at one per cycle while m_tready is high, set by the RAM's single read port.
// Input is held off (s_tready low) after the closing LF until the last word
// is taken; m_tready low simply holds the current word.
// Reset clears the line byte counter, CR flag and match state; RAM contents are not reset.

module crlf_line_framer_with_match
    import cfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] line_byte
    output logic            m_tlast,   // is_last
    output logic            m_tuser    // [0] http_action
);

    cmd_t cmd;
    sts_t sts;

    // sequencing: take bytes, then walk the stored line out
    cfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // line RAM, CRLF detect, match search, readout index
    cfm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .rx_byte     (s_tdata),
        .line_byte   (m_tdata),
        .is_last     (m_tlast),
        .http_action (m_tuser)
    );

endmodule

`default_nettype wire
